/* rtl/nlds_pkg.sv */
// Shared types and constants for the night light dimming scheduler.
// No dependencies; every other rtl file refers to it by scoped names.
package nlds_pkg;

  localparam int SECS_W  = 12;
  localparam int HOURS_W = 16;
  localparam int LEVEL_W = 10;
  localparam int DUTY_W  = 7;
  localparam int PHASE_W = 3;
  localparam int MODE_W  = 3;
  localparam int STEP_W  = 40;
  localparam int STEPS   = 5;
  localparam int APB_DW  = 64;
  localparam int APB_AW  = 6;
  localparam int REG_W   = 3;

  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [DUTY_W-1:0]  duty_t;
  typedef logic [REG_W-1:0]   reg_idx_t;

  // schedule modes
  localparam mode_t MODE_THREE_STEP  = 3'd0;
  localparam mode_t MODE_SPLIT_6H    = 3'd1;
  localparam mode_t MODE_SPLIT_9H    = 3'd2;
  localparam mode_t MODE_SECONDS     = 3'd3;
  localparam mode_t MODE_FIVE_STEP   = 3'd4;
  localparam mode_t MODE_FIXED_TABLE = 3'd5;
  localparam mode_t MODE_CUSTOM      = 3'd6;

  // schedule phases
  localparam phase_t PHASE_DARK = 3'd0;
  localparam phase_t PHASE_1    = 3'd1;
  localparam phase_t PHASE_2    = 3'd2;
  localparam phase_t PHASE_3    = 3'd3;
  localparam phase_t PHASE_4    = 3'd4;
  localparam phase_t PHASE_5    = 3'd5;
  localparam phase_t PHASE_6    = 3'd6;

  // duty levels in percent
  localparam duty_t DUTY_OFF  = 7'd0;
  localparam duty_t DUTY_FULL = 7'd100;
  localparam duty_t DUTY_80   = 7'd80;
  localparam duty_t DUTY_75   = 7'd75;
  localparam duty_t DUTY_60   = 7'd60;
  localparam duty_t DUTY_50   = 7'd50;

  // configuration register indexes (byte address is 8 * index)
  localparam reg_idx_t REG_MODE        = 3'd0;
  localparam reg_idx_t REG_ON_LEVEL    = 3'd1;
  localparam reg_idx_t REG_OFF_LEVEL   = 3'd2;
  localparam reg_idx_t REG_DIM_DUTY    = 3'd3;
  localparam reg_idx_t REG_STEP_LENS   = 3'd4;
  localparam reg_idx_t REG_STEP_DUTIES = 3'd5;

  typedef struct packed {
    mode_t              mode;
    duty_t              dim_duty;
    logic [STEP_W-1:0]  step_lens;
    logic [STEP_W-1:0]  step_duties;
  } sched_cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   load;
    duty_t  duty;
  } sched_res_t;

  typedef struct packed {
    logic all_low;
    logic all_high;
  } win_flags_t;

  function automatic duty_t sat100(input logic [7:0] v);
    return (v > 8'd100) ? DUTY_FULL : v[DUTY_W-1:0];
  endfunction

endpackage

/* rtl/nlds_window.sv */
// Sensor sample window: circular store, write pointer and level tests.
// Depends on nlds_pkg.
module nlds_window #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [nlds_pkg::LEVEL_W-1:0] sample,
  input  logic [nlds_pkg::LEVEL_W-1:0] on_level,
  input  logic [nlds_pkg::LEVEL_W-1:0] off_level,
  output nlds_pkg::win_flags_t         flags
);

  localparam int POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

  logic [nlds_pkg::LEVEL_W-1:0] win_r   [WINDOW_LEN];
  logic [nlds_pkg::LEVEL_W-1:0] win_nxt [WINDOW_LEN];
  logic [POS_W-1:0]             pos_r, pos_nxt;
  logic                         primed_r;

  // flags look at the window as it stands after this sample is written
  always_comb begin
    logic lo, hi;
    lo = 1'b1;
    hi = 1'b1;
    for (int k = 0; k < WINDOW_LEN; k++) begin
      win_nxt[k] = (!primed_r || (pos_r == POS_W'(k))) ? sample : win_r[k];
      if (!(win_nxt[k] < off_level)) lo = 1'b0;
      if (!(win_nxt[k] > on_level)) hi = 1'b0;
    end
    flags.all_low  = lo;
    flags.all_high = hi;
  end

  assign pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + POS_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < WINDOW_LEN; k++) win_r[k] <= win_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      primed_r <= 1'b0;
    end else if (wr_en) begin
      pos_r    <= pos_nxt;
      primed_r <= 1'b1;
    end
  end

endmodule

/* rtl/nlds_sched.sv */
// Schedule evaluation: phase from mode, hours and seconds, and the duty for that phase.
// Depends on nlds_pkg; purely combinational.
module nlds_sched (
  input  nlds_pkg::sched_cfg_t         cfg,
  input  logic [nlds_pkg::HOURS_W-1:0] hours,
  input  logic [nlds_pkg::SECS_W-1:0]  secs,
  input  nlds_pkg::phase_t             cur_phase,
  output nlds_pkg::sched_res_t         res
);

  nlds_pkg::phase_t custom_phase;
  nlds_pkg::phase_t ph;

  // mode 6: walk the cumulative step lengths, first end above secs wins
  always_comb begin
    logic [10:0] end_v;
    logic        found;
    end_v        = '0;
    found        = 1'b0;
    custom_phase = nlds_pkg::PHASE_6;
    for (int k = 0; k < nlds_pkg::STEPS; k++) begin
      end_v = end_v + {3'b000, cfg.step_lens[8*k +: 8]};
      if (!found && (secs < {1'b0, end_v})) begin
        found        = 1'b1;
        custom_phase = nlds_pkg::PHASE_W'(k + 1);
      end
    end
  end

  always_comb begin
    case (cfg.mode)
      nlds_pkg::MODE_THREE_STEP:
        ph = (hours < 16'd6) ? nlds_pkg::PHASE_1 :
             (hours < 16'd10) ? nlds_pkg::PHASE_2 : nlds_pkg::PHASE_3;
      nlds_pkg::MODE_SPLIT_6H:
        ph = (hours < 16'd6) ? nlds_pkg::PHASE_1 : nlds_pkg::PHASE_2;
      nlds_pkg::MODE_SPLIT_9H:
        ph = (hours < 16'd9) ? nlds_pkg::PHASE_1 : nlds_pkg::PHASE_2;
      nlds_pkg::MODE_SECONDS:
        ph = (secs < 12'd10) ? nlds_pkg::PHASE_1 :
             (secs < 12'd20) ? nlds_pkg::PHASE_2 : nlds_pkg::PHASE_3;
      nlds_pkg::MODE_FIVE_STEP:
        ph = (hours < 16'd1)  ? nlds_pkg::PHASE_1 :
             (hours < 16'd4)  ? nlds_pkg::PHASE_2 :
             (hours < 16'd5)  ? nlds_pkg::PHASE_3 :
             (hours < 16'd12) ? nlds_pkg::PHASE_4 : nlds_pkg::PHASE_5;
      nlds_pkg::MODE_FIXED_TABLE:
        ph = (hours < 16'd5)  ? nlds_pkg::PHASE_1 :
             (hours < 16'd7)  ? nlds_pkg::PHASE_2 :
             (hours < 16'd11) ? nlds_pkg::PHASE_3 :
             (hours < 16'd12) ? nlds_pkg::PHASE_4 : nlds_pkg::PHASE_5;
      nlds_pkg::MODE_CUSTOM:
        ph = custom_phase;
      default:
        ph = cur_phase;  // unused mode: hold the phase
    endcase
  end

  // duty for the new phase; load low means keep the previous duty
  always_comb begin
    res.phase = ph;
    res.load  = 1'b0;
    res.duty  = nlds_pkg::DUTY_OFF;
    if (ph == nlds_pkg::PHASE_DARK) begin
      res.load = 1'b1;
    end else if (cfg.mode == nlds_pkg::MODE_FIXED_TABLE) begin
      res.load = 1'b1;
      case (ph)
        nlds_pkg::PHASE_1: res.duty = nlds_pkg::DUTY_FULL;
        nlds_pkg::PHASE_2: res.duty = nlds_pkg::DUTY_75;
        nlds_pkg::PHASE_3: res.duty = nlds_pkg::DUTY_50;
        nlds_pkg::PHASE_4: res.duty = nlds_pkg::DUTY_60;
        nlds_pkg::PHASE_5: res.duty = nlds_pkg::DUTY_60;
        default:           res.load = 1'b0;
      endcase
    end else if (cfg.mode == nlds_pkg::MODE_CUSTOM) begin
      res.load = 1'b1;
      case (ph)
        nlds_pkg::PHASE_1: res.duty = nlds_pkg::sat100(cfg.step_duties[7:0]);
        nlds_pkg::PHASE_2: res.duty = nlds_pkg::sat100(cfg.step_duties[15:8]);
        nlds_pkg::PHASE_3: res.duty = nlds_pkg::sat100(cfg.step_duties[23:16]);
        nlds_pkg::PHASE_4: res.duty = nlds_pkg::sat100(cfg.step_duties[31:24]);
        nlds_pkg::PHASE_5: res.duty = nlds_pkg::sat100(cfg.step_duties[39:32]);
        default:           res.duty = nlds_pkg::DUTY_OFF;
      endcase
    end else begin
      case (ph)
        nlds_pkg::PHASE_1: begin
          res.load = 1'b1;
          res.duty = nlds_pkg::DUTY_FULL;
        end
        nlds_pkg::PHASE_2: begin
          res.load = 1'b1;
          res.duty = nlds_pkg::sat100({1'b0, cfg.dim_duty});
        end
        nlds_pkg::PHASE_3: begin
          res.load = 1'b1;
          res.duty = nlds_pkg::DUTY_80;
        end
        default: res.load = 1'b0;
      endcase
    end
  end

endmodule

/* rtl/night_light_dimming_scheduler.sv */
// Top level of the night light dimming scheduler: APB registers, input register,
// night clock, lamp state and result channel. Uses nlds_pkg, nlds_window, nlds_sched.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_cmd, in_sample   | into block
//   out     | out_valid, out_stall, out_lamp_on,      | out of block
//           | out_duty, out_phase, out_timing         |
//   config  | psel, penable, pwrite, paddr, pwdata,   | APB, 64-bit
//           | prdata, pready                          |
//
// A transaction passes the input register, then the state/result registers, which update
// state and present the result. One transaction per cycle is sustained when not stalled;
// the window test, schedule and duty select are evaluated between those registers.
// Synchronous active-low reset clears the window pointer, lamp, clock and registers.
// A stalled result holds; the input register still takes one more transaction behind it.
module night_light_dimming_scheduler #(
  parameter int WINDOW_LEN     = 5,
  parameter int TICKS_PER_HOUR = 3600
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [nlds_pkg::LEVEL_W-1:0]     in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_lamp_on,
  output logic [nlds_pkg::DUTY_W-1:0]      out_duty,
  output logic [nlds_pkg::PHASE_W-1:0]     out_phase,
  output logic                             out_timing,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [nlds_pkg::APB_AW-1:0]      paddr,
  input  logic [nlds_pkg::APB_DW-1:0]      pwdata,
  output logic [nlds_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  // configuration registers
  nlds_pkg::mode_t                mode_r;
  logic [nlds_pkg::LEVEL_W-1:0]   on_level_r;
  logic [nlds_pkg::LEVEL_W-1:0]   off_level_r;
  nlds_pkg::duty_t                dim_duty_r;
  logic [nlds_pkg::STEP_W-1:0]    step_lens_r;
  logic [nlds_pkg::STEP_W-1:0]    step_duties_r;

  nlds_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;

  // input register
  logic                         in_valid_r;
  logic                         cmd_r;
  logic [nlds_pkg::LEVEL_W-1:0] sample_r;

  // state, which doubles as the result payload
  logic                          lamp_r, lamp_nxt, lamp_mid;
  logic                          running_r, running_nxt, running_mid;
  logic [nlds_pkg::SECS_W-1:0]   secs_r, secs_nxt, secs_mid;
  logic [nlds_pkg::HOURS_W-1:0]  hours_r, hours_nxt, hours_mid;
  nlds_pkg::phase_t              phase_r, phase_nxt, phase_mid;
  nlds_pkg::duty_t               duty_r, duty_nxt, duty_mid;
  logic                          out_valid_r;

  logic [nlds_pkg::SECS_W:0] secs_inc;
  logic                      advance;
  logic                      process;
  logic                      is_sample;

  nlds_pkg::win_flags_t flags;
  nlds_pkg::sched_cfg_t sched_cfg;
  nlds_pkg::sched_res_t sched_res;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= nlds_pkg::MODE_THREE_STEP;
      on_level_r    <= '0;
      off_level_r   <= '0;
      dim_duty_r    <= nlds_pkg::DUTY_50;
      step_lens_r   <= '0;
      step_duties_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        nlds_pkg::REG_MODE:        mode_r        <= pwdata[nlds_pkg::MODE_W-1:0];
        nlds_pkg::REG_ON_LEVEL:    on_level_r    <= pwdata[nlds_pkg::LEVEL_W-1:0];
        nlds_pkg::REG_OFF_LEVEL:   off_level_r   <= pwdata[nlds_pkg::LEVEL_W-1:0];
        nlds_pkg::REG_DIM_DUTY:    dim_duty_r    <= pwdata[nlds_pkg::DUTY_W-1:0];
        nlds_pkg::REG_STEP_LENS:   step_lens_r   <= pwdata[nlds_pkg::STEP_W-1:0];
        nlds_pkg::REG_STEP_DUTIES: step_duties_r <= pwdata[nlds_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nlds_pkg::REG_MODE:        prdata = nlds_pkg::APB_DW'(mode_r);
      nlds_pkg::REG_ON_LEVEL:    prdata = nlds_pkg::APB_DW'(on_level_r);
      nlds_pkg::REG_OFF_LEVEL:   prdata = nlds_pkg::APB_DW'(off_level_r);
      nlds_pkg::REG_DIM_DUTY:    prdata = nlds_pkg::APB_DW'(dim_duty_r);
      nlds_pkg::REG_STEP_LENS:   prdata = nlds_pkg::APB_DW'(step_lens_r);
      nlds_pkg::REG_STEP_DUTIES: prdata = nlds_pkg::APB_DW'(step_duties_r);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  assign advance  = !out_valid_r || !out_stall;
  assign process  = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) in_valid_r <= 1'b1;
      else if (advance)          in_valid_r <= 1'b0;
      if (process)               out_valid_r <= 1'b1;
      else if (!out_stall)       out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r    <= in_cmd;
      sample_r <= in_sample;
    end
  end

  // ---------------------------------------------------------------- datapath
  assign is_sample = cmd_r;

  nlds_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (process && is_sample),
    .sample    (sample_r),
    .on_level  (on_level_r),
    .off_level (off_level_r),
    .flags     (flags)
  );

  assign secs_inc = {1'b0, secs_r} + (nlds_pkg::SECS_W+1)'(1);

  // tick handling and the dark/light tests
  always_comb begin
    lamp_mid    = lamp_r;
    running_mid = running_r;
    secs_mid    = secs_r;
    hours_mid   = hours_r;
    phase_mid   = phase_r;
    duty_mid    = duty_r;
    if (!is_sample) begin
      if (running_r) begin
        if (secs_inc >= (nlds_pkg::SECS_W+1)'(TICKS_PER_HOUR)) begin
          secs_mid  = '0;
          hours_mid = hours_r + nlds_pkg::HOURS_W'(1);
        end else begin
          secs_mid = secs_inc[nlds_pkg::SECS_W-1:0];
        end
      end
    end else if (flags.all_low) begin
      if (lamp_r) begin
        lamp_mid    = 1'b0;
        duty_mid    = nlds_pkg::DUTY_OFF;
        running_mid = 1'b0;
      end
      phase_mid = nlds_pkg::PHASE_DARK;
      secs_mid  = '0;
      hours_mid = '0;
    end else if (flags.all_high) begin
      lamp_mid = 1'b1;
      if (!running_r) begin
        secs_mid    = '0;
        hours_mid   = '0;
        running_mid = 1'b1;
      end
      if (phase_r == nlds_pkg::PHASE_DARK) duty_mid = nlds_pkg::DUTY_FULL;
    end
  end

  assign sched_cfg.mode        = mode_r;
  assign sched_cfg.dim_duty    = dim_duty_r;
  assign sched_cfg.step_lens   = step_lens_r;
  assign sched_cfg.step_duties = step_duties_r;

  nlds_sched u_sched (
    .cfg       (sched_cfg),
    .hours     (hours_mid),
    .secs      (secs_mid),
    .cur_phase (phase_mid),
    .res       (sched_res)
  );

  // re-evaluate the schedule on samples while lit
  always_comb begin
    lamp_nxt    = lamp_mid;
    running_nxt = running_mid;
    secs_nxt    = secs_mid;
    hours_nxt   = hours_mid;
    phase_nxt   = phase_mid;
    duty_nxt    = duty_mid;
    if (is_sample && lamp_mid && (sched_res.phase != phase_mid)) begin
      phase_nxt = sched_res.phase;
      if (sched_res.load) duty_nxt = sched_res.duty;
    end
  end

  // state only moves when the result slot frees, so it holds the pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_r    <= 1'b0;
      running_r <= 1'b0;
      secs_r    <= '0;
      hours_r   <= '0;
      phase_r   <= nlds_pkg::PHASE_DARK;
      duty_r    <= nlds_pkg::DUTY_OFF;
    end else if (process) begin
      lamp_r    <= lamp_nxt;
      running_r <= running_nxt;
      secs_r    <= secs_nxt;
      hours_r   <= hours_nxt;
      phase_r   <= phase_nxt;
      duty_r    <= duty_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_lamp_on = lamp_r;
  assign out_duty    = duty_r;
  assign out_phase   = phase_r;
  assign out_timing  = running_r;

  // ---------------------------------------------------------------- assertions
  a_lamp_tracks_clock: assert property (@(posedge clk) disable iff (!rst_n)
    lamp_r == running_r)
    else $error("lamp and night clock disagree");

  a_dark_clears: assert property (@(posedge clk) disable iff (!rst_n)
    !lamp_r |-> (phase_r == nlds_pkg::PHASE_DARK) && (secs_r == '0) && (hours_r == '0))
    else $error("dark state left phase or clock set");

  a_secs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, secs_r} < (nlds_pkg::SECS_W+1)'(TICKS_PER_HOUR)) && (duty_r <= nlds_pkg::DUTY_FULL))
    else $error("seconds or duty out of range");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(duty_r) && $stable(phase_r) && $stable(lamp_r))
    else $error("result changed while stalled");

endmodule

/* bench/night_light_dimming_scheduler_tb.sv */
// Self-checking bench for the night light dimming scheduler: lux window, night clock,
// schedule phases and duty. Needs nlds_pkg and the rtl of night_light_dimming_scheduler.
module night_light_dimming_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 5;
  localparam int SECS_PER_HOUR = 3600;
  localparam int HOLD_CYCLES = 60;
  localparam int SEGMENTS = 8;
  localparam int SEGMENT_ITEMS = 80;

  typedef struct packed {
    logic             lamp;
    nlds_pkg::duty_t  duty;
    nlds_pkg::phase_t phase;
    logic             timing;
  } lamp_view_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_cmd = 1'b0;
  logic [nlds_pkg::LEVEL_W-1:0]  in_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_lamp_on;
  logic [nlds_pkg::DUTY_W-1:0]   out_duty;
  logic [nlds_pkg::PHASE_W-1:0]  out_phase;
  logic                          out_timing;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [nlds_pkg::APB_AW-1:0]   paddr = '0;
  logic [nlds_pkg::APB_DW-1:0]   pwdata = '0;
  logic [nlds_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  night_light_dimming_scheduler #(
    .WINDOW_LEN    (WIN),
    .TICKS_PER_HOUR(SECS_PER_HOUR)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_lamp_on(out_lamp_on),
    .out_duty   (out_duty),
    .out_phase  (out_phase),
    .out_timing (out_timing),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial forever #6 clk = ~clk;

  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // lamp model state
  logic [nlds_pkg::LEVEL_W-1:0] lux_win [WIN] = '{default: '0};
  int                           lux_ptr = 0;
  bit                           lux_primed = 1'b0;
  bit                           lamp_lit = 1'b0;
  bit                           clock_run = 1'b0;
  logic [nlds_pkg::SECS_W-1:0]  sec_cnt = '0;
  logic [nlds_pkg::HOURS_W-1:0] hour_cnt = '0;
  nlds_pkg::phase_t             cur_phase = nlds_pkg::PHASE_DARK;
  nlds_pkg::duty_t              cur_duty = nlds_pkg::DUTY_OFF;

  // register copies
  nlds_pkg::mode_t              set_mode = nlds_pkg::MODE_THREE_STEP;
  logic [nlds_pkg::LEVEL_W-1:0] set_on = '0;
  logic [nlds_pkg::LEVEL_W-1:0] set_off = '0;
  nlds_pkg::duty_t              set_dim = nlds_pkg::DUTY_50;
  logic [nlds_pkg::STEP_W-1:0]  set_lens = '0;
  logic [nlds_pkg::STEP_W-1:0]  set_duties = '0;

  lamp_view_t lamp_views [$];
  int         err_count = 0;
  int         send_gap_pct = 36;
  int         recv_gap_pct = 60;
  int         hold_requests = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  int         traffic_items = 0;

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    err_count++;
  endtask

  function automatic nlds_pkg::duty_t clip_duty(logic [7:0] pct);
    return (pct > 8'd100) ? nlds_pkg::DUTY_FULL : nlds_pkg::duty_t'(pct);
  endfunction

  function automatic nlds_pkg::phase_t schedule_for_time();
    int step_end;
    step_end = 0;
    case (set_mode)
      nlds_pkg::MODE_THREE_STEP:
        return (hour_cnt < 6) ? nlds_pkg::PHASE_1 :
               (hour_cnt < 10) ? nlds_pkg::PHASE_2 : nlds_pkg::PHASE_3;
      nlds_pkg::MODE_SPLIT_6H:
        return (hour_cnt < 6) ? nlds_pkg::PHASE_1 : nlds_pkg::PHASE_2;
      nlds_pkg::MODE_SPLIT_9H:
        return (hour_cnt < 9) ? nlds_pkg::PHASE_1 : nlds_pkg::PHASE_2;
      nlds_pkg::MODE_SECONDS:
        return (sec_cnt < 10) ? nlds_pkg::PHASE_1 :
               (sec_cnt < 20) ? nlds_pkg::PHASE_2 : nlds_pkg::PHASE_3;
      nlds_pkg::MODE_FIVE_STEP: begin
        if (hour_cnt < 1) return nlds_pkg::PHASE_1;
        if (hour_cnt < 4) return nlds_pkg::PHASE_2;
        if (hour_cnt < 5) return nlds_pkg::PHASE_3;
        if (hour_cnt < 12) return nlds_pkg::PHASE_4;
        return nlds_pkg::PHASE_5;
      end
      nlds_pkg::MODE_FIXED_TABLE: begin
        if (hour_cnt < 5) return nlds_pkg::PHASE_1;
        if (hour_cnt < 7) return nlds_pkg::PHASE_2;
        if (hour_cnt < 11) return nlds_pkg::PHASE_3;
        if (hour_cnt < 12) return nlds_pkg::PHASE_4;
        return nlds_pkg::PHASE_5;
      end
      nlds_pkg::MODE_CUSTOM: begin
        // steps are back to back; a zero-length step is skipped
        for (int k = 0; k < nlds_pkg::STEPS; k++) begin
          step_end += set_lens[8*k +: 8];
          if (sec_cnt < step_end) return nlds_pkg::phase_t'(k + 1);
        end
        return nlds_pkg::PHASE_6;
      end
      default: return cur_phase;
    endcase
  endfunction

  function automatic nlds_pkg::duty_t duty_on_entry(nlds_pkg::phase_t ph);
    if (ph == nlds_pkg::PHASE_DARK) return nlds_pkg::DUTY_OFF;
    case (set_mode)
      nlds_pkg::MODE_FIXED_TABLE: begin
        case (ph)
          nlds_pkg::PHASE_1:                    return nlds_pkg::DUTY_FULL;
          nlds_pkg::PHASE_2:                    return nlds_pkg::DUTY_75;
          nlds_pkg::PHASE_3:                    return nlds_pkg::DUTY_50;
          nlds_pkg::PHASE_4, nlds_pkg::PHASE_5: return nlds_pkg::DUTY_60;
          default:                              return cur_duty;
        endcase
      end
      nlds_pkg::MODE_CUSTOM: begin
        if (ph <= nlds_pkg::PHASE_5) return clip_duty(set_duties[8*(ph-1) +: 8]);
        return nlds_pkg::DUTY_OFF;
      end
      default: begin
        // phases 4 and 5 carry no duty of their own here
        case (ph)
          nlds_pkg::PHASE_1: return nlds_pkg::DUTY_FULL;
          nlds_pkg::PHASE_2: return clip_duty({1'b0, set_dim});
          nlds_pkg::PHASE_3: return nlds_pkg::DUTY_80;
          default:           return cur_duty;
        endcase
      end
    endcase
  endfunction

  task automatic predict_lamp_view(bit cmd, logic [nlds_pkg::LEVEL_W-1:0] lux);
    bit               all_low;
    bit               all_high;
    nlds_pkg::phase_t ph;
    if (!cmd) begin
      if (clock_run) begin
        sec_cnt++;
        if (sec_cnt >= SECS_PER_HOUR) begin
          sec_cnt = '0;
          hour_cnt++;
        end
      end
    end else begin
      if (!lux_primed) begin
        foreach (lux_win[k]) lux_win[k] = lux;
        lux_primed = 1'b1;
      end
      lux_win[lux_ptr] = lux;
      lux_ptr = (lux_ptr == WIN - 1) ? 0 : lux_ptr + 1;
      all_low = 1'b1;
      all_high = 1'b1;
      foreach (lux_win[k]) begin
        if (!(lux_win[k] < set_off)) all_low = 1'b0;
        if (!(lux_win[k] > set_on)) all_high = 1'b0;
      end
      if (all_low) begin
        if (lamp_lit) begin
          lamp_lit = 1'b0;
          cur_duty = nlds_pkg::DUTY_OFF;
          clock_run = 1'b0;
        end
        cur_phase = nlds_pkg::PHASE_DARK;
        sec_cnt = '0;
        hour_cnt = '0;
      end else if (all_high) begin
        lamp_lit = 1'b1;
        if (!clock_run) begin
          sec_cnt = '0;
          hour_cnt = '0;
          clock_run = 1'b1;
        end
        if (cur_phase == nlds_pkg::PHASE_DARK) cur_duty = nlds_pkg::DUTY_FULL;
      end
      if (lamp_lit) begin
        ph = schedule_for_time();
        if (ph != cur_phase) begin
          cur_duty = duty_on_entry(ph);
          cur_phase = ph;
        end
      end
    end
    lamp_views.push_back('{lamp_lit, cur_duty, cur_phase, clock_run});
  endtask

  // sink: random stall, or a long hold when a test asks for one
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_gap_pct != 0) && ($urandom_range(99, 0) < recv_gap_pct);
    end
  end

  always @(posedge clk) begin : check_results
    lamp_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lamp_views.size() == 0) begin
        report_mismatch("unexpected transaction",
                        32'({out_lamp_on, out_duty, out_phase}), 32'(0));
      end else begin
        want = lamp_views.pop_front();
        if (out_lamp_on !== want.lamp)
          report_mismatch("lamp_on", 32'(out_lamp_on), 32'(want.lamp));
        if (out_duty !== want.duty)
          report_mismatch("duty", 32'(out_duty), 32'(want.duty));
        if (out_phase !== want.phase)
          report_mismatch("phase", 32'(out_phase), 32'(want.phase));
        if (out_timing !== want.timing)
          report_mismatch("timing", 32'(out_timing), 32'(want.timing));
      end
    end
  end

  task automatic send_item(bit cmd, logic [nlds_pkg::LEVEL_W-1:0] lux);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_sample <= lux;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_lamp_view(cmd, lux);
  endtask

  // drop valid and let every outstanding transaction come back
  task automatic finish_batch();
    in_valid <= 1'b0;
    do @(posedge clk); while (lamp_views.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(nlds_pkg::reg_idx_t idx, logic [nlds_pkg::APB_DW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      nlds_pkg::REG_MODE:        set_mode = value[nlds_pkg::MODE_W-1:0];
      nlds_pkg::REG_ON_LEVEL:    set_on = value[nlds_pkg::LEVEL_W-1:0];
      nlds_pkg::REG_OFF_LEVEL:   set_off = value[nlds_pkg::LEVEL_W-1:0];
      nlds_pkg::REG_DIM_DUTY:    set_dim = value[nlds_pkg::DUTY_W-1:0];
      nlds_pkg::REG_STEP_LENS:   set_lens = value[nlds_pkg::STEP_W-1:0];
      nlds_pkg::REG_STEP_DUTIES: set_duties = value[nlds_pkg::STEP_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [nlds_pkg::LEVEL_W-1:0] any_lux();
    return nlds_pkg::LEVEL_W'($urandom_range(1023, 0));
  endfunction

  function automatic logic [nlds_pkg::LEVEL_W-1:0] bright_lux();
    if (set_on == 10'h3FF) return any_lux();
    return nlds_pkg::LEVEL_W'($urandom_range(1023, set_on + 1));
  endfunction

  function automatic logic [nlds_pkg::LEVEL_W-1:0] dark_lux();
    if (set_off == 0) return '0;
    return nlds_pkg::LEVEL_W'($urandom_range(set_off - 1, 0));
  endfunction

  // random upper bits that the register must ignore
  function automatic logic [nlds_pkg::APB_DW-1:0] with_noise(logic [nlds_pkg::APB_DW-1:0] v,
                                                             int w);
    return ({$urandom(), $urandom()} << w) | v;
  endfunction

  task automatic test_reset_values();
    send_item(1'b0, any_lux());
    send_item(1'b1, 10'd0);
    repeat (5) send_item(1'b1, 10'd1);
    send_item(1'b0, any_lux());
  endtask

  task automatic test_directed_edges();
    finish_batch();
    write_reg(nlds_pkg::REG_MODE, 64'(nlds_pkg::MODE_THREE_STEP));
    write_reg(nlds_pkg::REG_ON_LEVEL, 64'd600);
    write_reg(nlds_pkg::REG_OFF_LEVEL, 64'd200);
    write_reg(nlds_pkg::REG_DIM_DUTY, 64'h7F);
    write_reg(nlds_pkg::REG_STEP_LENS, 64'h05_02_04_00_03);
    write_reg(nlds_pkg::REG_STEP_DUTIES, 64'h1E_FF_4D_00_78);
    send_item(1'b1, 10'd0);
    send_item(1'b0, any_lux());
    repeat (5) send_item(1'b1, 10'h3FF);
    repeat (2) send_item(1'b0, any_lux());
    send_item(1'b1, 10'd400);
    send_item(1'b1, 10'h3FF);
    repeat (5) send_item(1'b1, 10'd0);
    repeat (3) send_item(1'b1, 10'd400);
  endtask

  task automatic test_schedule_modes();
    for (int m = 0; m < 8; m++) begin
      finish_batch();
      write_reg(nlds_pkg::REG_MODE, 64'(m));
      repeat (5) send_item(1'b1, 10'd0);
      repeat (5) send_item(1'b1, 10'h3FF);
      repeat (6) begin
        repeat (4) send_item(1'b0, any_lux());
        send_item(1'b1, 10'h3FF);
      end
    end
  endtask

  // walk the custom steps through every phase, past the last step end
  task automatic test_night_clock();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    finish_batch();
    write_reg(nlds_pkg::REG_STEP_LENS, 64'h28_20_18_10_0C);
    write_reg(nlds_pkg::REG_STEP_DUTIES, 64'h64_50_3C_28_14);
    write_reg(nlds_pkg::REG_MODE, 64'(nlds_pkg::MODE_CUSTOM));
    repeat (5) send_item(1'b1, 10'd0);
    repeat (5) send_item(1'b1, 10'h3FF);
    repeat (8) begin
      repeat (20) send_item(1'b0, any_lux());
      send_item(1'b1, 10'h3FF);
    end
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_requests++;
    repeat (30) send_item($urandom_range(1, 0), any_lux());
  endtask

  task automatic offer_random(bit cmd, logic [nlds_pkg::LEVEL_W-1:0] lux);
    traffic_items++;
    send_item(cmd, lux);
  endtask

  task automatic randomize_settings(int seg);
    nlds_pkg::mode_t              mode_v;
    logic [nlds_pkg::LEVEL_W-1:0] on_v;
    logic [nlds_pkg::LEVEL_W-1:0] off_v;
    nlds_pkg::duty_t              dim_v;
    logic [nlds_pkg::STEP_W-1:0]  lens_v;
    logic [nlds_pkg::STEP_W-1:0]  duties_v;
    finish_batch();
    if (seg == 0) begin
      mode_v = nlds_pkg::MODE_THREE_STEP;
      on_v = '0;
      off_v = '0;
      dim_v = '0;
      lens_v = '0;
      duties_v = '0;
    end else if (seg == 1) begin
      mode_v = nlds_pkg::MODE_CUSTOM;
      on_v = '1;
      off_v = '1;
      dim_v = '1;
      lens_v = '1;
      duties_v = '1;
    end else begin
      mode_v = nlds_pkg::mode_t'($urandom_range(7, 0));
      off_v = nlds_pkg::LEVEL_W'($urandom_range(400, 1));
      on_v = nlds_pkg::LEVEL_W'($urandom_range(900, off_v));
      dim_v = nlds_pkg::duty_t'($urandom_range(127, 0));
      for (int k = 0; k < nlds_pkg::STEPS; k++) lens_v[8*k +: 8] = 8'($urandom_range(40, 0));
      if ($urandom_range(3, 0) == 0) lens_v = nlds_pkg::STEP_W'({$urandom(), $urandom()});
      duties_v = nlds_pkg::STEP_W'({$urandom(), $urandom()});
    end
    write_reg(nlds_pkg::REG_MODE, with_noise(64'(mode_v), nlds_pkg::MODE_W));
    write_reg(nlds_pkg::REG_ON_LEVEL, with_noise(64'(on_v), nlds_pkg::LEVEL_W));
    write_reg(nlds_pkg::REG_OFF_LEVEL, with_noise(64'(off_v), nlds_pkg::LEVEL_W));
    write_reg(nlds_pkg::REG_DIM_DUTY, with_noise(64'(dim_v), nlds_pkg::DUTY_W));
    write_reg(nlds_pkg::REG_STEP_LENS, with_noise(64'(lens_v), nlds_pkg::STEP_W));
    write_reg(nlds_pkg::REG_STEP_DUTIES, with_noise(64'(duties_v), nlds_pkg::STEP_W));
  endtask

  task automatic test_random_traffic();
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      randomize_settings(seg);
      send_gap_pct = (seg < 3) ? 36 : (seg < 6) ? 60 : 0;
      recv_gap_pct = (seg < 3) ? 60 : (seg < 6) ? 36 : 0;
      traffic_items = 0;
      while (traffic_items < SEGMENT_ITEMS) begin
        case ($urandom_range(9, 0))
          0, 1, 2, 3: repeat (5) offer_random(1'b1, bright_lux());
          4, 5:       repeat ($urandom_range(40, 1)) offer_random(1'b0, any_lux());
          6:          repeat (5) offer_random(1'b1, dark_lux());
          7:          offer_random(1'b1, any_lux());
          8:          repeat ($urandom_range(5, 1)) offer_random($urandom_range(1, 0), any_lux());
          default: begin
            // bright run broken before the window fills
            repeat ($urandom_range(4, 2)) offer_random(1'b1, bright_lux());
            offer_random(1'b1, dark_lux());
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed_edges();
    test_schedule_modes();
    test_night_clock();
    send_gap_pct = 36;
    recv_gap_pct = 60;
    test_backpressure();
    test_random_traffic();
    finish_batch();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
